>>> sv/plane_moving_average_macros.svh
// ----------------------------------------------------------------------------
// plane moving average assertion macros
// shared concurrent assertion helpers for the plane moving average rtl
// ----------------------------------------------------------------------------
`ifndef PLANE_MOVING_AVERAGE_MACROS_SVH
`define PLANE_MOVING_AVERAGE_MACROS_SVH

// property must hold at every clock edge outside reset
`define PMA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// condition must never be true outside reset
`define PMA_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `PMA_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

>>> sv/pma_pkg.sv
// ----------------------------------------------------------------------------
// plane moving average package
// shared types and constants for the plane moving average block
// ----------------------------------------------------------------------------
package pma_pkg;

  localparam int NUM_LANES = 7;
  localparam int OUT_W     = 32;
  localparam int CFG_W     = 6;

  localparam logic [CFG_W-1:0] WINDOW_RESET = 6'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } pma_state_e;

  typedef struct packed {
    logic capture;
    logic clear;
    logic rd_en;
    logic update;
    logic evict;
    logic load;
    logic step;
  } pma_lane_ctrl_t;

endpackage

>>> sv/pma_ram.sv
// ----------------------------------------------------------------------------
// pma ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module pma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/pma_lane.sv
// ----------------------------------------------------------------------------
// pma lane
// one component: sample history, running sum and serial signed divider
// ----------------------------------------------------------------------------
module pma_lane import pma_pkg::*; #(
  parameter int SAMPLE_BITS = 32,
  parameter int MAX_WINDOW  = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pma_lane_ctrl_t                  ctrl_i,
  input  logic [SAMPLE_BITS-1:0]          sample_i,
  input  logic [$clog2(MAX_WINDOW)-1:0]   addr_i,
  input  logic [$clog2(MAX_WINDOW+1)-1:0] divisor_i,
  output logic [OUT_W-1:0]                result_o
);

  localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int EXT_W = (SUM_W > OUT_W) ? SUM_W : OUT_W;

  logic [SAMPLE_BITS-1:0] sample_q;
  logic [SAMPLE_BITS-1:0] old_sample;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [SUM_W-1:0]       dq_q, dq_d;
  logic [CNT_W-1:0]       rem_q, rem_d;
  logic                   neg_q;
  logic [CNT_W:0]         rem_shift;
  logic                   qbit;
  logic [SUM_W-1:0]       quot;
  logic [EXT_W-1:0]       quot_ext;

  pma_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MAX_WINDOW)
  ) u_hist (
    .clk_i  (clk_i),
    .we_i   (ctrl_i.update),
    .waddr_i(addr_i),
    .wdata_i(sample_q),
    .re_i   (ctrl_i.rd_en),
    .raddr_i(addr_i),
    .rdata_o(old_sample)
  );

  always_comb begin
    sum_d = sum_q + SUM_W'($signed(sample_q));
    if (ctrl_i.evict) begin
      sum_d = sum_d - SUM_W'($signed(old_sample));
    end
  end

  // restoring division, one quotient bit per step
  always_comb begin
    rem_shift = {rem_q, dq_q[SUM_W-1]};
    qbit      = (rem_shift >= {1'b0, divisor_i});
    rem_d     = qbit ? CNT_W'(rem_shift - {1'b0, divisor_i}) : rem_shift[CNT_W-1:0];
    dq_d      = {dq_q[SUM_W-2:0], qbit};
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      sample_q <= sample_i;
    end
    if (ctrl_i.load) begin
      neg_q <= sum_q[SUM_W-1];
      dq_q  <= sum_q[SUM_W-1] ? (~sum_q + 1'b1) : sum_q;
      rem_q <= '0;
    end else if (ctrl_i.step) begin
      dq_q  <= dq_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (ctrl_i.clear) begin
      sum_q <= '0;
    end else if (ctrl_i.update) begin
      sum_q <= sum_d;
    end
  end

  assign quot     = neg_q ? (~dq_q + 1'b1) : dq_q;
  assign quot_ext = EXT_W'($signed(quot));
  assign result_o = quot_ext[OUT_W-1:0];

endmodule

>>> sv/pma_merge.sv
// ----------------------------------------------------------------------------
// pma merge
// gathers the lane quotients, keeps the last result and drives the output
// ----------------------------------------------------------------------------
module pma_merge import pma_pkg::*; (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             done_i,
  input  logic                             present_i,
  input  logic [NUM_LANES-1:0][OUT_W-1:0]  lane_res_i,
  input  logic                             out_stall_i,
  output logic                             taken_o,
  output logic                             out_valid_o,
  output logic                             result_valid_o,
  output logic [NUM_LANES-1:0][OUT_W-1:0]  avg_o
);

  logic [NUM_LANES-1:0][OUT_W-1:0] last_q, last_d;
  logic                            have_q, have_d;
  logic                            out_valid_q;
  logic                            res_valid_q;
  logic [NUM_LANES-1:0][OUT_W-1:0] avg_q;

  assign taken_o = done_i && (!out_valid_q || !out_stall_i);
  assign last_d  = present_i ? lane_res_i : last_q;
  assign have_d  = present_i | have_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= '0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (taken_o) begin
        last_q      <= last_d;
        have_q      <= have_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (taken_o) begin
      avg_q       <= last_d;
      res_valid_q <= have_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_valid_o = res_valid_q;
  assign avg_o          = avg_q;

endmodule

>>> sv/plane_moving_average.sv
// ----------------------------------------------------------------------------
// plane moving average
// windowed mean of seven signed plane components, one lane per component
// ----------------------------------------------------------------------------
// A transfer with plane_present set passes from acceptance through the
// history read, sum update and divider load states, then through the serial
// divider that every lane owns at one quotient bit per cycle, then the merge,
// to a result ready for the output register. A transfer without a sample
// goes straight to the merge and repeats the last result. The next input is
// taken once the previous result sits in the output register. Writing
// cfg_wdata_i sets the window (0 acts as 1, values above MAX_WINDOW act as
// MAX_WINDOW) and starts averaging afresh; write only while no transfer is in
// progress.
// ----------------------------------------------------------------------------
`include "plane_moving_average_macros.svh"

module plane_moving_average import pma_pkg::*; #(
  parameter int MAX_WINDOW  = 32,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   plane_present_i,
  input  logic [SAMPLE_BITS-1:0] normal_x_i,
  input  logic [SAMPLE_BITS-1:0] normal_y_i,
  input  logic [SAMPLE_BITS-1:0] normal_z_i,
  input  logic [SAMPLE_BITS-1:0] origin_x_i,
  input  logic [SAMPLE_BITS-1:0] origin_y_i,
  input  logic [SAMPLE_BITS-1:0] origin_z_i,
  input  logic [SAMPLE_BITS-1:0] plane_offset_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   result_valid_o,
  output logic [OUT_W-1:0]       avg_normal_x_o,
  output logic [OUT_W-1:0]       avg_normal_y_o,
  output logic [OUT_W-1:0]       avg_normal_z_o,
  output logic [OUT_W-1:0]       avg_origin_x_o,
  output logic [OUT_W-1:0]       avg_origin_y_o,
  output logic [OUT_W-1:0]       avg_origin_z_o,
  output logic [OUT_W-1:0]       avg_plane_offset_o
);

  localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int PTR_W  = $clog2(MAX_WINDOW);
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int STEP_W = $clog2(SUM_W);

  pma_state_e       state_q, state_d;
  logic [CFG_W-1:0] window_q;
  logic [CNT_W-1:0] eff_win;
  logic [CNT_W-1:0] fill_q;
  logic [PTR_W-1:0] wpos_q;
  logic [PTR_W-1:0] pos;
  logic [CNT_W-1:0] pos_next;
  logic             present_q, present_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic             in_xfer;
  logic             done;
  logic             taken;
  pma_lane_ctrl_t   ctrl;

  logic [NUM_LANES-1:0][SAMPLE_BITS-1:0] samples;
  logic [NUM_LANES-1:0][OUT_W-1:0]       lane_res;
  logic [NUM_LANES-1:0][OUT_W-1:0]       avg;

  assign samples = {plane_offset_i, origin_z_i, origin_y_i, origin_x_i,
                    normal_z_i, normal_y_i, normal_x_i};

  always_comb begin
    if (cfg_wdata_i == '0 && window_q == '0) begin
      eff_win = CNT_W'(1);
    end else if (32'(window_q) > 32'(MAX_WINDOW)) begin
      eff_win = CNT_W'(MAX_WINDOW);
    end else if (window_q == '0) begin
      eff_win = CNT_W'(1);
    end else begin
      eff_win = CNT_W'(window_q);
    end
  end

  assign pos      = (CNT_W'(wpos_q) >= eff_win) ? '0 : wpos_q;
  assign pos_next = CNT_W'(pos) + 1'b1;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_comb begin
    state_d      = state_q;
    present_d    = present_q;
    step_d       = step_q;
    ctrl         = '0;
    ctrl.clear   = cfg_we_i;
    done         = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          ctrl.capture = 1'b1;
          present_d    = plane_present_i;
          state_d      = plane_present_i ? ST_READ : ST_DONE;
        end
      end
      ST_READ: begin
        ctrl.rd_en = 1'b1;
        state_d    = ST_UPDATE;
      end
      ST_UPDATE: begin
        ctrl.update = 1'b1;
        ctrl.evict  = (fill_q >= eff_win);
        state_d     = ST_LOAD;
      end
      ST_LOAD: begin
        ctrl.load = 1'b1;
        step_d    = STEP_W'(SUM_W - 1);
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        ctrl.step = 1'b1;
        if (step_q == '0) begin
          state_d = ST_DONE;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      ST_DONE: begin
        done = 1'b1;
        if (taken) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      present_q <= 1'b0;
      step_q    <= '0;
    end else begin
      state_q   <= state_d;
      present_q <= present_d;
      step_q    <= step_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WINDOW_RESET;
      fill_q   <= '0;
      wpos_q   <= '0;
    end else if (cfg_we_i) begin
      window_q <= cfg_wdata_i;
      fill_q   <= '0;
      wpos_q   <= '0;
    end else if (ctrl.update) begin
      if (fill_q < eff_win) begin
        fill_q <= fill_q + 1'b1;
      end else begin
        fill_q <= eff_win;
      end
      wpos_q <= (pos_next == eff_win) ? '0 : pos_next[PTR_W-1:0];
    end
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    pma_lane #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .MAX_WINDOW (MAX_WINDOW)
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .sample_i (samples[g]),
      .addr_i   (pos),
      .divisor_i(fill_q),
      .result_o (lane_res[g])
    );
  end

  pma_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .done_i        (done),
    .present_i     (present_q),
    .lane_res_i    (lane_res),
    .out_stall_i   (out_stall_i),
    .taken_o       (taken),
    .out_valid_o   (out_valid_o),
    .result_valid_o(result_valid_o),
    .avg_o         (avg)
  );

  assign avg_normal_x_o     = avg[0];
  assign avg_normal_y_o     = avg[1];
  assign avg_normal_z_o     = avg[2];
  assign avg_origin_x_o     = avg[3];
  assign avg_origin_y_o     = avg[4];
  assign avg_origin_z_o     = avg[5];
  assign avg_plane_offset_o = avg[6];

  `PMA_ASSERT(a_fill_in_window, clk_i, rst_ni, fill_q <= eff_win, "fill count exceeds window")
  `PMA_ASSERT(a_wpos_in_window, clk_i, rst_ni,
              state_q == ST_IDLE |-> CNT_W'(wpos_q) < eff_win, "write position out of window")
  `PMA_ASSERT(a_present_reads, clk_i, rst_ni,
              in_xfer && plane_present_i |=> state_q == ST_READ, "sample transfer skipped read")
  `PMA_ASSERT(a_out_from_done, clk_i, rst_ni,
              $rose(out_valid_o) |-> $past(state_q == ST_DONE), "result without finished item")
  `PMA_ASSERT_NEVER(a_div_by_zero, clk_i, rst_ni,
                    (state_q == ST_DIV) && (fill_q == '0), "divide by empty window")

endmodule

>>> test/plane_moving_average_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// plane moving average checker
// watches the input, output and window register ports of the plane moving
// average, keeps its own copy of the sample ring and running sums, works out
// the windowed means for every accepted input transfer and compares each
// accepted output transfer against the oldest mean still awaited
// ----------------------------------------------------------------------------
module plane_moving_average_checker import pma_pkg::*; #(
  parameter int MAX_WINDOW = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [CFG_W-1:0]                  cfg_wdata_i,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic                              plane_present_i,
  input  logic [NUM_LANES-1:0][OUT_W-1:0]   sample_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic                              result_valid_i,
  input  logic [NUM_LANES-1:0][OUT_W-1:0]   mean_i,
  output int                                mismatch_count_o,
  output int                                pending_o
);

  localparam int SUM_W = OUT_W + 5;

  typedef logic [NUM_LANES-1:0][OUT_W-1:0] plane_t;

  typedef struct packed {
    logic   valid;
    plane_t mean;
  } plane_mean_t;

  string lane_name [NUM_LANES] = '{"avg_normal_x", "avg_normal_y", "avg_normal_z",
                                   "avg_origin_x", "avg_origin_y", "avg_origin_z",
                                   "avg_plane_offset"};

  logic [CFG_W-1:0]        window_reg;
  logic signed [OUT_W-1:0] ring [MAX_WINDOW][NUM_LANES];
  logic signed [SUM_W-1:0] lane_sum [NUM_LANES];
  logic [CFG_W-1:0]        fill;
  int                      slot;
  plane_t                  last_mean;
  logic                    have_mean;
  plane_mean_t             expected_means [$];
  int                      errors;

  function automatic void restart_window();
    for (int c = 0; c < NUM_LANES; c++) lane_sum[c] = '0;
    fill = '0;
    slot = 0;
  endfunction

  function automatic plane_mean_t window_mean_step(input logic present, input plane_t s);
    plane_mean_t             res;
    int                      span;
    int                      pos;
    logic signed [SUM_W-1:0] quot;
    if (present) begin
      span = (window_reg == 0) ? 1 : (window_reg > MAX_WINDOW) ? MAX_WINDOW : int'(window_reg);
      pos = (slot >= span) ? 0 : slot;
      for (int c = 0; c < NUM_LANES; c++) begin
        if (fill >= span) lane_sum[c] = lane_sum[c] - ring[pos][c];
        ring[pos][c] = $signed(s[c]);
        lane_sum[c] = lane_sum[c] + $signed(s[c]);
      end
      if (fill < span) fill = fill + 1'b1;
      slot = (pos + 1) % span;
      for (int c = 0; c < NUM_LANES; c++) begin
        // signed division truncates toward zero
        quot = lane_sum[c] / $signed({1'b0, fill});
        last_mean[c] = quot[OUT_W-1:0];
      end
      have_mean = 1'b1;
    end
    res.valid = have_mean;
    res.mean  = last_mean;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    plane_mean_t exp_mean;
    if (!rst_ni) begin
      window_reg = WINDOW_RESET;
      restart_window();
      last_mean = '0;
      have_mean = 1'b0;
      expected_means.delete();
      errors = 0;
      mismatch_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        window_reg = cfg_wdata_i;
        restart_window();
      end
      if (in_valid_i && !in_stall_i)
        expected_means.push_back(window_mean_step(plane_present_i, sample_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_means.size() == 0) begin
          $display("%0t: unexpected output transfer, expected none, actual valid %b",
                   $realtime, result_valid_i);
          errors++;
        end else begin
          exp_mean = expected_means.pop_front();
          if (result_valid_i !== exp_mean.valid) begin
            $display("%0t: result_valid expected %b actual %b", $realtime,
                     exp_mean.valid, result_valid_i);
            errors++;
          end
          for (int c = 0; c < NUM_LANES; c++)
            if (mean_i[c] !== exp_mean.mean[c]) begin
              $display("%0t: %s expected %h actual %h", $realtime, lane_name[c],
                       exp_mean.mean[c], mean_i[c]);
              errors++;
            end
        end
      end
      pending_o <= expected_means.size();
      mismatch_count_o <= errors;
    end
  end

endmodule

>>> test/plane_moving_average_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// plane moving average testbench
// drives plane samples and window settings into the plane moving average:
// a directed run over extreme components, missing samples and edge windows,
// then random phases at several windows with sender gaps, receiver stalls
// and one long output hold-off; a checker beside the block scores results
// ----------------------------------------------------------------------------
module plane_moving_average_test;
  import pma_pkg::*;

  localparam int MAX_WINDOW  = 32;
  localparam int SAMPLE_BITS = 32;

  typedef logic [NUM_LANES-1:0][SAMPLE_BITS-1:0] plane_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             in_valid = 1'b0;
  logic             plane_present = 1'b0;
  plane_t           sample = '0;
  logic             out_stall = 1'b0;
  wire              in_stall;
  wire              out_valid;
  wire              result_valid;
  wire [NUM_LANES-1:0][OUT_W-1:0] avg;

  int sender_idle_pct = 0;
  int stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int mismatches;
  int means_pending;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  plane_moving_average #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) i_dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_wdata_i        (cfg_wdata),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .plane_present_i    (plane_present),
    .normal_x_i         (sample[0]),
    .normal_y_i         (sample[1]),
    .normal_z_i         (sample[2]),
    .origin_x_i         (sample[3]),
    .origin_y_i         (sample[4]),
    .origin_z_i         (sample[5]),
    .plane_offset_i     (sample[6]),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .result_valid_o     (result_valid),
    .avg_normal_x_o     (avg[0]),
    .avg_normal_y_o     (avg[1]),
    .avg_normal_z_o     (avg[2]),
    .avg_origin_x_o     (avg[3]),
    .avg_origin_y_o     (avg[4]),
    .avg_origin_z_o     (avg[5]),
    .avg_plane_offset_o (avg[6])
  );

  plane_moving_average_checker #(
    .MAX_WINDOW (MAX_WINDOW)
  ) i_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .plane_present_i  (plane_present),
    .sample_i         (sample),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .result_valid_i   (result_valid),
    .mean_i           (avg),
    .mismatch_count_o (mismatches),
    .pending_o        (means_pending)
  );

  // receiver: random stalls, or a long hold-off when requested
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic plane_t random_plane();
    plane_t p;
    for (int c = 0; c < NUM_LANES; c++)
      case ($urandom_range(7))
        0: p[c] = 32'h7fff_ffff;
        1: p[c] = 32'h8000_0000;
        2: p[c] = 32'($urandom_range(16)) - 32'd8;
        default: p[c] = $urandom;
      endcase
    return p;
  endfunction

  task automatic send_plane(input logic present, input plane_t comps);
    int gap;
    in_valid <= 1'b1;
    plane_present <= present;
    sample <= comps;
    do @(posedge clk); while (in_stall);
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_window(input logic [CFG_W-1:0] w);
    in_valid <= 1'b0;
    do @(posedge clk); while (means_pending != 0);
    repeat (2) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int mode;
    logic [CFG_W-1:0] w;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset window of 8: no sample yet, extremes, truncation, eviction
    send_plane(1'b0, random_plane());
    send_plane(1'b1, {NUM_LANES{32'h7fff_ffff}});
    send_plane(1'b1, {NUM_LANES{32'h8000_0000}});
    send_plane(1'b1, '0);
    send_plane(1'b1, {NUM_LANES{32'hffff_ffff}});
    send_plane(1'b1, {32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                      32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff});
    send_plane(1'b0, random_plane());
    send_plane(1'b1, {NUM_LANES{32'h0000_0001}});
    send_plane(1'b1, {NUM_LANES{32'hffff_fffd}});
    repeat (3) send_plane(1'b1, random_plane());

    // zero window acts as one, last mean survives the write
    load_window(6'd0);
    send_plane(1'b0, random_plane());
    send_plane(1'b1, {NUM_LANES{32'h7fff_ffff}});
    send_plane(1'b1, {NUM_LANES{32'h8000_0000}});

    // window above the maximum acts as the maximum
    load_window(6'd63);
    repeat (4) send_plane(1'b1, {NUM_LANES{32'h8000_0000}});
    send_plane(1'b0, random_plane());

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: w = 6'd1;
        1: w = 6'd32;
        2: w = 6'd63;
        3: w = 6'd0;
        4: w = 6'($urandom_range(31, 2));
        5: w = 6'($urandom_range(62, 33));
        6: w = 6'($urandom_range(63, 0));
        default: w = 6'd32;
      endcase
      load_window(w);
      mode = p % 4;
      sender_idle_pct = (mode == 1) ? 87 : (mode == 3) ? 38 : 0;
      stall_pct = (mode == 2) ? 87 : (mode == 3) ? 38 : 0;
      if (p == 4) hold_request = 400;
      repeat (50) send_plane($urandom_range(99) < 85, random_plane());
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (means_pending != 0);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && means_pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
